FILE: rtl/dq_pkg.sv
// Shared types and request codes for the double-ended queue.
// No dependencies; used by dq_engine, dq_obuf, double_ended_queue and the test files.
package dq_pkg;

	localparam logic [1:0] REQ_PUSH_FRONT = 2'd0;
	localparam logic [1:0] REQ_PUSH_BACK  = 2'd1;
	localparam logic [1:0] REQ_POP_FRONT  = 2'd2;
	localparam logic [1:0] REQ_POP_BACK   = 2'd3;

	localparam int COUNT_OUT_W = 11;

	typedef struct packed {
		logic [1:0]         req_type;
		logic signed [63:0] push_value;
	} req_t;

	typedef struct packed {
		logic signed [63:0]     front_value;
		logic signed [63:0]     back_value;
		logic [COUNT_OUT_W-1:0] entry_count;
		logic                   is_empty;
		logic                   dropped;
	} rsp_t;

endpackage

FILE: rtl/dq_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module dq_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 1024
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic                                   re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: rtl/dq_engine.sv
// Queue control: front/back pointers, count, cached end values, slot RAM access.
// Depends on dq_pkg and dq_ram.
module dq_engine #(
	parameter int DEPTH = 1024
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  dq_pkg::req_t  req,
	input  logic          hold_busy,
	output logic          eng_valid,
	output dq_pkg::rsp_t  eng_rsp
);

	localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [IW-1:0] IDX_LAST = IW'(DEPTH - 1);
	localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);
	localparam logic [CW-1:0] CNT_ONE  = CW'(1);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_READ = 1'b1;

	logic              state_q, state_d;
	logic [IW-1:0]     front_idx_q, front_idx_d;
	logic [IW-1:0]     back_idx_q, back_idx_d;   // one past the back entry
	logic [CW-1:0]     count_q, count_d;
	logic signed [63:0] front_val_q, front_val_d;
	logic signed [63:0] back_val_q, back_val_d;
	logic              pend_front_q, pend_front_d;

	logic          accept;
	logic          drop;
	logic          we, re;
	logic [IW-1:0] waddr, raddr;
	logic [63:0]   rdata;

	function automatic logic [IW-1:0] idx_inc(input logic [IW-1:0] i);
		return (i == IDX_LAST) ? '0 : i + IW'(1);
	endfunction

	function automatic logic [IW-1:0] idx_dec(input logic [IW-1:0] i);
		return (i == '0) ? IDX_LAST : i - IW'(1);
	endfunction

	assign req_stall = (state_q != ST_IDLE) | hold_busy;
	assign accept    = req_valid & ~req_stall;

	always_comb begin
		state_d      = state_q;
		front_idx_d  = front_idx_q;
		back_idx_d   = back_idx_q;
		count_d      = count_q;
		front_val_d  = front_val_q;
		back_val_d   = back_val_q;
		pend_front_d = pend_front_q;
		we           = 1'b0;
		waddr        = back_idx_q;
		re           = 1'b0;
		raddr        = front_idx_q;
		drop         = 1'b0;
		eng_valid    = 1'b0;

		if (state_q == ST_IDLE) begin
			if (accept) begin
				unique case (req.req_type)
					dq_pkg::REQ_PUSH_FRONT: begin
						eng_valid = 1'b1;
						if (count_q == CNT_FULL) begin
							drop = 1'b1;
						end else begin
							front_idx_d = idx_dec(front_idx_q);
							we          = 1'b1;
							waddr       = idx_dec(front_idx_q);
							front_val_d = req.push_value;
							if (count_q == '0) begin
								back_val_d = req.push_value;
							end
							count_d = count_q + CNT_ONE;
						end
					end
					dq_pkg::REQ_PUSH_BACK: begin
						eng_valid = 1'b1;
						if (count_q == CNT_FULL) begin
							drop = 1'b1;
						end else begin
							back_idx_d = idx_inc(back_idx_q);
							we         = 1'b1;
							waddr      = back_idx_q;
							back_val_d = req.push_value;
							if (count_q == '0) begin
								front_val_d = req.push_value;
							end
							count_d = count_q + CNT_ONE;
						end
					end
					dq_pkg::REQ_POP_FRONT: begin
						if (count_q == '0) begin
							drop      = 1'b1;
							eng_valid = 1'b1;
						end else begin
							front_idx_d = idx_inc(front_idx_q);
							count_d     = count_q - CNT_ONE;
							if (count_q == CNT_ONE) begin
								eng_valid = 1'b1;
							end else begin
								// new front comes back from the RAM next cycle
								re           = 1'b1;
								raddr        = idx_inc(front_idx_q);
								pend_front_d = 1'b1;
								state_d      = ST_READ;
							end
						end
					end
					dq_pkg::REQ_POP_BACK: begin
						if (count_q == '0) begin
							drop      = 1'b1;
							eng_valid = 1'b1;
						end else begin
							back_idx_d = idx_dec(back_idx_q);
							count_d    = count_q - CNT_ONE;
							if (count_q == CNT_ONE) begin
								eng_valid = 1'b1;
							end else begin
								re           = 1'b1;
								raddr        = idx_dec(idx_dec(back_idx_q));
								pend_front_d = 1'b0;
								state_d      = ST_READ;
							end
						end
					end
					default: begin
						eng_valid = 1'b0;
					end
				endcase
			end
		end else begin
			if (pend_front_q) begin
				front_val_d = $signed(rdata);
			end else begin
				back_val_d = $signed(rdata);
			end
			eng_valid = 1'b1;
			state_d   = ST_IDLE;
		end
	end

	always_comb begin
		eng_rsp.front_value = (count_d == '0) ? '0 : front_val_d;
		eng_rsp.back_value  = (count_d == '0) ? '0 : back_val_d;
		eng_rsp.entry_count = dq_pkg::COUNT_OUT_W'(count_d);
		eng_rsp.is_empty    = (count_d == '0);
		eng_rsp.dropped     = drop;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			front_idx_q <= '0;
			back_idx_q  <= '0;
			count_q     <= '0;
		end else begin
			state_q     <= state_d;
			front_idx_q <= front_idx_d;
			back_idx_q  <= back_idx_d;
			count_q     <= count_d;
		end
	end

	always_ff @(posedge clk) begin
		front_val_q  <= front_val_d;
		back_val_q   <= back_val_d;
		pend_front_q <= pend_front_d;
	end

	dq_ram #(
		.WIDTH(64),
		.DEPTH(DEPTH)
	) u_slots (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(req.push_value),
		.re   (re),
		.raddr(raddr),
		.rdata(rdata)
	);

`ifndef NO_ASSERTIONS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_FULL)
		else $error("entry count beyond depth");

	a_read_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_READ |-> count_q != '0)
		else $error("slot read with an empty queue");

	a_no_result_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		eng_valid |-> !hold_busy)
		else $error("result produced while the hold stage is full");

	a_read_one_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_READ |=> state_q == ST_IDLE)
		else $error("read state lasted more than one cycle");
`endif

endmodule

FILE: rtl/dq_obuf.sv
// Result buffer: output register plus one hold stage so a new request can be
// taken while a result waits. Depends on dq_pkg.
module dq_obuf (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         eng_valid,
	input  dq_pkg::rsp_t eng_rsp,
	output logic         hold_busy,
	output logic         rsp_valid,
	input  logic         rsp_stall,
	output dq_pkg::rsp_t rsp
);

	logic         out_valid_q;
	logic         hold_valid_q;
	dq_pkg::rsp_t out_q;
	dq_pkg::rsp_t hold_q;
	logic         out_free;

	assign out_free  = ~out_valid_q | ~rsp_stall;
	assign rsp_valid = out_valid_q;
	assign rsp       = out_q;
	assign hold_busy = hold_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			hold_valid_q <= 1'b0;
		end else begin
			if (hold_valid_q) begin
				if (out_free) begin
					out_valid_q  <= 1'b1;
					hold_valid_q <= 1'b0;
				end
			end else if (eng_valid) begin
				if (out_free) begin
					out_valid_q <= 1'b1;
				end else begin
					hold_valid_q <= 1'b1;
				end
			end else if (!rsp_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (hold_valid_q) begin
			if (out_free) begin
				out_q <= hold_q;
			end
		end else if (eng_valid) begin
			if (out_free) begin
				out_q <= eng_rsp;
			end else begin
				hold_q <= eng_rsp;
			end
		end
	end

endmodule

FILE: rtl/double_ended_queue.sv
// Bounded double-ended queue of signed 64-bit values held in a circular slot
// RAM of DEPTH entries. Each request beat pushes or pops at either end and
// yields one result beat with the front and back values (0 when empty), the
// count, an empty flag and a drop flag (push on full, pop on empty). A pop
// that leaves entries behind passes through a read state, as the new end
// value is read back from the slot RAM, whose read data is registered; other
// requests need no read. One request is in work at a time; a finished result
// waiting on a stalled output blocks the next request only if the hold stage
// is full too. Depends on dq_pkg, dq_engine, dq_obuf, dq_ram.
module double_ended_queue #(
	parameter int DEPTH = 1024
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         req_valid,
	output logic         req_stall,
	input  dq_pkg::req_t req,
	output logic         rsp_valid,
	input  logic         rsp_stall,
	output dq_pkg::rsp_t rsp
);

	logic         eng_valid;
	logic         hold_busy;
	dq_pkg::rsp_t eng_rsp;

	dq_engine #(
		.DEPTH(DEPTH)
	) u_engine (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req      (req),
		.hold_busy(hold_busy),
		.eng_valid(eng_valid),
		.eng_rsp  (eng_rsp)
	);

	dq_obuf u_obuf (
		.clk      (clk),
		.arst_n   (arst_n),
		.eng_valid(eng_valid),
		.eng_rsp  (eng_rsp),
		.hold_busy(hold_busy),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp      (rsp)
	);

endmodule

FILE: test/dq_result_checker.sv
// Passive checker for the double-ended queue: watches both channels, tracks the
// queue contents and compares every result beat. Depends on dq_pkg.
module dq_result_checker #(
	parameter int DEPTH = 1024
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         req_valid,
	input  logic         req_stall,
	input  dq_pkg::req_t req,
	input  logic         rsp_valid,
	input  logic         rsp_stall,
	input  dq_pkg::rsp_t rsp,
	output int           fail_count,
	output int           pending
);
	timeunit 1ns;
	timeprecision 1ps;

	logic [63:0]  slot_copy [DEPTH];
	int           head_slot;
	int           tail_slot;
	int           live_count;
	dq_pkg::rsp_t predicted_views [$];

	// Applies one request to the shadow queue and returns the view of both ends.
	function automatic dq_pkg::rsp_t deque_apply(input dq_pkg::req_t r);
		dq_pkg::rsp_t v;
		v.dropped = 1'b0;
		case (r.req_type)
			dq_pkg::REQ_PUSH_FRONT: begin
				if (live_count >= DEPTH) begin
					v.dropped = 1'b1;
				end else begin
					head_slot = (head_slot + DEPTH - 1) % DEPTH;
					slot_copy[head_slot] = r.push_value;
					live_count++;
				end
			end
			dq_pkg::REQ_PUSH_BACK: begin
				if (live_count >= DEPTH) begin
					v.dropped = 1'b1;
				end else begin
					slot_copy[tail_slot] = r.push_value;
					tail_slot = (tail_slot + 1) % DEPTH;
					live_count++;
				end
			end
			dq_pkg::REQ_POP_FRONT: begin
				if (live_count == 0) begin
					v.dropped = 1'b1;
				end else begin
					head_slot = (head_slot + 1) % DEPTH;
					live_count--;
				end
			end
			default: begin
				if (live_count == 0) begin
					v.dropped = 1'b1;
				end else begin
					tail_slot = (tail_slot + DEPTH - 1) % DEPTH;
					live_count--;
				end
			end
		endcase
		if (live_count == 0) begin
			v.front_value = '0;
			v.back_value = '0;
		end else begin
			v.front_value = slot_copy[head_slot];
			v.back_value = slot_copy[(tail_slot + DEPTH - 1) % DEPTH];
		end
		v.entry_count = dq_pkg::COUNT_OUT_W'(live_count);
		v.is_empty = (live_count == 0);
		return v;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		dq_pkg::rsp_t want;
		if (!arst_n) begin
			head_slot = 0;
			tail_slot = 0;
			live_count = 0;
			predicted_views.delete();
			pending = 0;
		end else begin
			// result side first, so a beat accepted on this edge cannot match itself
			if (rsp_valid && !rsp_stall) begin
				if (predicted_views.size() == 0) begin
					$error("result beat with no request outstanding");
					fail_count++;
				end else begin
					want = predicted_views.pop_front();
					if (rsp.front_value !== want.front_value) begin
						$error("front_value: expected %0d, actual %0d",
							want.front_value, rsp.front_value);
						fail_count++;
					end
					if (rsp.back_value !== want.back_value) begin
						$error("back_value: expected %0d, actual %0d",
							want.back_value, rsp.back_value);
						fail_count++;
					end
					if (rsp.entry_count !== want.entry_count) begin
						$error("entry_count: expected %0d, actual %0d",
							want.entry_count, rsp.entry_count);
						fail_count++;
					end
					if (rsp.is_empty !== want.is_empty) begin
						$error("is_empty: expected %0b, actual %0b",
							want.is_empty, rsp.is_empty);
						fail_count++;
					end
					if (rsp.dropped !== want.dropped) begin
						$error("dropped: expected %0b, actual %0b",
							want.dropped, rsp.dropped);
						fail_count++;
					end
				end
			end
			if (req_valid && !req_stall)
				predicted_views.push_back(deque_apply(req));
			pending = predicted_views.size();
		end
	end

endmodule

FILE: test/tb_double_ended_queue.sv
// Top of the double-ended queue testbench: clock, reset, request stimulus and
// result back-pressure. Depends on dq_pkg, double_ended_queue, dq_result_checker.
module tb_double_ended_queue;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int          DEPTH       = 1024;
	localparam int          CYCLE_LIMIT = 400000;
	localparam int          DRAIN_WAIT  = 16;
	localparam int          HOLD_AT_A   = 400;
	localparam int          HOLD_AT_B   = 2000;
	localparam int          HOLD_LEN    = 120;
	localparam logic [63:0] VAL_MAX     = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam logic [63:0] VAL_MIN     = 64'h8000_0000_0000_0000;
	localparam logic [63:0] VAL_ONES    = 64'hFFFF_FFFF_FFFF_FFFF;
	localparam logic [63:0] VAL_ODD     = 64'h5555_5555_5555_5555;
	localparam logic [63:0] VAL_EVEN    = 64'hAAAA_AAAA_AAAA_AAAA;

	logic         clk;
	logic         arst_n;
	logic         req_valid;
	logic         req_stall;
	dq_pkg::req_t req;
	logic         rsp_valid;
	logic         rsp_stall;
	dq_pkg::rsp_t rsp;
	int           fail_count;
	int           pending;

	int   burst_left;
	int   fill_level;

	double_ended_queue #(.DEPTH(DEPTH)) DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	dq_result_checker #(.DEPTH(DEPTH)) u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_stall  (req_stall),
		.req        (req),
		.rsp_valid  (rsp_valid),
		.rsp_stall  (rsp_stall),
		.rsp        (rsp),
		.fail_count (fail_count),
		.pending    (pending)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		int n;
		n = 0;
		while (n < CYCLE_LIMIT) begin
			@(posedge clk);
			n++;
		end
		$display("Simulation FAILED");
		$finish;
	end

	function automatic logic [63:0] rand_value();
		case ($urandom_range(0, 11))
			0:       return VAL_MAX;
			1:       return VAL_MIN;
			2:       return '0;
			3:       return VAL_ONES;
			default: return {$urandom, $urandom};
		endcase
	endfunction

	function automatic logic [1:0] rand_push_kind();
		return $urandom_range(0, 1) ? dq_pkg::REQ_PUSH_BACK : dq_pkg::REQ_PUSH_FRONT;
	endfunction

	function automatic logic [1:0] rand_pop_kind();
		return $urandom_range(0, 1) ? dq_pkg::REQ_POP_BACK : dq_pkg::REQ_POP_FRONT;
	endfunction

	// Called at a falling edge; returns at the falling edge after the beat is taken.
	task automatic issue(input logic [1:0] kind, input logic [63:0] value);
		int           gap;
		dq_pkg::req_t beat;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				req_valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		burst_left--;
		beat.req_type = kind;
		beat.push_value = value;
		req <= beat;
		req_valid <= 1'b1;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		@(negedge clk);
		if (kind == dq_pkg::REQ_PUSH_FRONT || kind == dq_pkg::REQ_PUSH_BACK) begin
			if (fill_level < DEPTH)
				fill_level++;
		end else if (fill_level > 0) begin
			fill_level--;
		end
	endtask

	// Result side: stall pattern picked at random from four modes, plus two long hold-offs.
	initial begin
		int cyc;
		int mode;
		rsp_stall = 1'b0;
		cyc = 0;
		mode = 0;
		wait (arst_n);
		forever begin
			@(negedge clk);
			cyc++;
			if (cyc == HOLD_AT_A || cyc == HOLD_AT_B) begin
				rsp_stall <= 1'b1;
				repeat (HOLD_LEN - 1) @(negedge clk);
				cyc += HOLD_LEN - 1;
			end else begin
				if (cyc % 50 == 0)
					mode = $urandom_range(0, 3);
				case (mode)
					0:       rsp_stall <= 1'b0;
					1:       rsp_stall <= ($urandom_range(0, 3) == 0);
					2:       rsp_stall <= ($urandom_range(0, 3) != 0);
					default: rsp_stall <= (cyc % 3 == 0);
				endcase
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		req_valid = 1'b0;
		req = '0;
		burst_left = 0;
		fill_level = 0;
		repeat (6) @(negedge clk);
		arst_n = 1'b1;

		// directed: pops on empty, extremes, both ends, back to empty
		issue(dq_pkg::REQ_POP_FRONT, rand_value());
		issue(dq_pkg::REQ_POP_BACK, rand_value());
		issue(dq_pkg::REQ_PUSH_FRONT, VAL_MAX);
		issue(dq_pkg::REQ_PUSH_BACK, VAL_MIN);
		issue(dq_pkg::REQ_PUSH_FRONT, VAL_ONES);
		issue(dq_pkg::REQ_PUSH_BACK, '0);
		issue(dq_pkg::REQ_PUSH_FRONT, VAL_ODD);
		issue(dq_pkg::REQ_PUSH_BACK, VAL_EVEN);
		issue(dq_pkg::REQ_POP_FRONT, rand_value());
		issue(dq_pkg::REQ_POP_BACK, rand_value());
		issue(dq_pkg::REQ_POP_FRONT, rand_value());
		issue(dq_pkg::REQ_POP_BACK, rand_value());
		issue(dq_pkg::REQ_POP_FRONT, rand_value());
		issue(dq_pkg::REQ_POP_BACK, rand_value());
		issue(dq_pkg::REQ_POP_FRONT, rand_value());
		issue(dq_pkg::REQ_PUSH_BACK, 64'd1);
		issue(dq_pkg::REQ_POP_FRONT, rand_value());
		issue(dq_pkg::REQ_PUSH_FRONT, VAL_MIN);
		issue(dq_pkg::REQ_POP_BACK, rand_value());
		issue(dq_pkg::REQ_PUSH_BACK, VAL_MAX);
		issue(dq_pkg::REQ_PUSH_FRONT, VAL_EVEN);
		issue(dq_pkg::REQ_POP_BACK, rand_value());
		issue(dq_pkg::REQ_POP_BACK, rand_value());
		issue(dq_pkg::REQ_POP_BACK, rand_value());

		// churn around empty
		repeat (40)
			issue(2'($urandom_range(0, 3)), rand_value());
		// fill to the top
		while (fill_level < DEPTH)
			issue(($urandom_range(0, 63) == 0) ? rand_pop_kind() : rand_push_kind(),
				rand_value());
		// pushes against a full queue
		repeat (24)
			issue(($urandom_range(0, 3) != 0) ? rand_push_kind() : rand_pop_kind(),
				rand_value());
		repeat (40)
			issue(($urandom_range(0, 3) != 0) ? rand_pop_kind() : rand_push_kind(),
				rand_value());
		req_valid <= 1'b0;

		while (pending != 0)
			@(negedge clk);
		repeat (DRAIN_WAIT) @(negedge clk);

		if (fail_count == 0 && pending == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

FILE: sim.f
rtl/dq_pkg.sv
rtl/dq_ram.sv
rtl/dq_engine.sv
rtl/dq_obuf.sv
rtl/double_ended_queue.sv
test/dq_result_checker.sv
test/tb_double_ended_queue.sv
